/* hdl/mjpi_pkg.sv */
// shared types, widths and constants for the multi-joint incremental pi controller
package mjpi_pkg;

  localparam int JOINT_W       = 3;
  localparam int LEVEL_W       = 12;
  localparam int GAIN_W        = 16;
  localparam int ERR_W         = 13;
  localparam int DRIVE_W       = 32;
  localparam int GAIN_FRAC     = 8;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 16;

  localparam int NUM_JOINTS_DEF = 6;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST     = 16'd25600;
  localparam logic [GAIN_W-1:0]  INTEGRAL_GAIN_RST = 16'd640;
  localparam logic [LEVEL_W-1:0] DRIVE_MIN_RST     = 12'd10;
  localparam logic [LEVEL_W-1:0] DRIVE_MAX_RST     = 12'd4090;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX     = 8'd3;

  typedef logic [JOINT_W-1:0]        joint_t;
  typedef logic [LEVEL_W-1:0]        level_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic signed [DRIVE_W-1:0] drive_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integral_gain;
    level_t            drive_min;
    level_t            drive_max;
  } cfg_t;

  typedef struct packed {
    err_t   err;
    drive_t next_drive;
    level_t drive;
    logic   clamped;
  } core_res_t;

endpackage

/* hdl/mjpi_state.sv */
// per-joint storage of the previous error and previous drive
module mjpi_state #(
  parameter int NUM_JOINTS = mjpi_pkg::NUM_JOINTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mjpi_pkg::joint_t joint,
  input  logic            wr_en,
  input  mjpi_pkg::err_t  wr_err,
  input  mjpi_pkg::drive_t wr_drive,
  output mjpi_pkg::err_t  rd_err,
  output mjpi_pkg::drive_t rd_drive
);

  localparam int IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  mjpi_pkg::err_t   err_r   [NUM_JOINTS];
  mjpi_pkg::drive_t drive_r [NUM_JOINTS];

  logic [mjpi_pkg::JOINT_W:0] joint_ext;
  logic [IDX_W-1:0]           idx;

  assign joint_ext = {1'b0, joint};
  assign idx       = joint_ext[IDX_W-1:0];

  assign rd_err   = err_r[idx];
  assign rd_drive = drive_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_JOINTS; i++) begin
        err_r[i]   <= '0;
        drive_r[i] <= '0;
      end
    end else if (wr_en) begin
      err_r[idx]   <= wr_err;
      drive_r[idx] <= wr_drive;
    end
  end

endmodule

/* hdl/mjpi_core.sv */
// pi update arithmetic: error, gain products, truncation, saturation and output clamp
module mjpi_core (
  input  mjpi_pkg::level_t    reference,
  input  mjpi_pkg::level_t    measured,
  input  mjpi_pkg::err_t      prev_err,
  input  mjpi_pkg::drive_t    prev_drive,
  input  mjpi_pkg::cfg_t      cfg,
  output mjpi_pkg::core_res_t res
);

  logic signed [12:0] err;
  logic signed [13:0] diff;
  logic signed [30:0] prod_p;
  logic signed [29:0] prod_i;
  logic signed [32:0] acc;
  logic signed [32:0] acc_adj;
  logic signed [24:0] term;
  logic signed [32:0] sum;
  mjpi_pkg::drive_t   next_drive;
  mjpi_pkg::drive_t   lo;
  mjpi_pkg::drive_t   hi;

  assign err  = $signed({1'b0, reference}) - $signed({1'b0, measured});
  assign diff = $signed({err[12], err}) - $signed({prev_err[12], prev_err});

  assign prod_p = $signed({1'b0, cfg.prop_gain}) * diff;
  assign prod_i = $signed({1'b0, cfg.integral_gain}) * prev_err;

  // truncate toward zero on the q8.8 scaling
  assign acc     = 33'(prod_p) + 33'(prod_i);
  assign acc_adj = acc + (acc[32] ? 33'sd255 : 33'sd0);
  assign term    = $signed(acc_adj[32:mjpi_pkg::GAIN_FRAC]);

  assign sum = 33'(prev_drive) + 33'(term);

  always_comb begin
    if (sum[32] != sum[31]) begin
      next_drive = sum[32] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
    end else begin
      next_drive = $signed(sum[31:0]);
    end
  end

  assign lo = $signed({20'd0, cfg.drive_min});
  assign hi = $signed({20'd0, cfg.drive_max});

  always_comb begin
    res.err        = err;
    res.next_drive = next_drive;
    if (next_drive < lo) begin
      res.drive   = cfg.drive_min;
      res.clamped = 1'b1;
    end else if (next_drive > hi) begin
      res.drive   = cfg.drive_max;
      res.clamped = 1'b1;
    end else begin
      res.drive   = next_drive[mjpi_pkg::LEVEL_W-1:0];
      res.clamped = 1'b0;
    end
  end

endmodule

/* hdl/multi_joint_incremental_pi.sv */
// top level of the multi-joint incremental pi controller
//
// input channel in_*: one transaction per sample, giving a joint number, a 12-bit
// reference and a 12-bit measurement. output channel out_*: one transaction per
// sample with the joint number, the clamped drive and a clamp flag.
// configuration channel cfg_*: index 0 prop_gain, 1 integral_gain, 2 drive_min,
// 3 drive_max; other indexes are dropped. write only while no sample is in flight.
// path: the accepting edge loads the input register, and the result then passes
// through the arithmetic into the output register once that register is free.
// throughput: one sample per cycle while out_ready is high, also on the same joint
// back to back, since the joint state is read and written in the cycle the sample
// leaves the input register.
// a joint number at or above the joint count gives drive 0, no flag, no state change.
// reset: synchronous, clears all joint state, loads the default gains and limits
// and empties both pipeline registers.
// when the receiver stalls, the output register holds its result, the input
// register still takes one more sample if it is empty, then in_ready drops.
module multi_joint_incremental_pi #(
  parameter int NUM_JOINTS = mjpi_pkg::NUM_JOINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mjpi_pkg::JOINT_W-1:0]      in_joint,
  input  logic [mjpi_pkg::LEVEL_W-1:0]      in_reference,
  input  logic [mjpi_pkg::LEVEL_W-1:0]      in_measured,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mjpi_pkg::JOINT_W-1:0]      out_joint_out,
  output logic [mjpi_pkg::LEVEL_W-1:0]      out_drive,
  output logic                              out_clamped,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mjpi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mjpi_pkg::CFG_DATA_W-1:0]   cfg_data
);

  mjpi_pkg::cfg_t      cfg_r;
  mjpi_pkg::cfg_t      cfg_nxt;

  logic                s1_valid_r;
  mjpi_pkg::joint_t    s1_joint_r;
  mjpi_pkg::level_t    s1_ref_r;
  mjpi_pkg::level_t    s1_meas_r;

  logic                out_valid_r;
  mjpi_pkg::joint_t    out_joint_r;
  mjpi_pkg::level_t    out_drive_r;
  logic                out_clamped_r;

  logic                advance;
  logic                in_range;
  mjpi_pkg::err_t      prev_err;
  mjpi_pkg::drive_t    prev_drive;
  mjpi_pkg::core_res_t res;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        mjpi_pkg::REG_PROP_GAIN:     cfg_nxt.prop_gain     = cfg_data;
        mjpi_pkg::REG_INTEGRAL_GAIN: cfg_nxt.integral_gain = cfg_data;
        mjpi_pkg::REG_DRIVE_MIN:     cfg_nxt.drive_min     = cfg_data[mjpi_pkg::LEVEL_W-1:0];
        mjpi_pkg::REG_DRIVE_MAX:     cfg_nxt.drive_max     = cfg_data[mjpi_pkg::LEVEL_W-1:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain     <= mjpi_pkg::PROP_GAIN_RST;
      cfg_r.integral_gain <= mjpi_pkg::INTEGRAL_GAIN_RST;
      cfg_r.drive_min     <= mjpi_pkg::DRIVE_MIN_RST;
      cfg_r.drive_max     <= mjpi_pkg::DRIVE_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  assign in_range = ({2'b0, s1_joint_r} < (mjpi_pkg::JOINT_W+2)'(NUM_JOINTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_joint_r <= in_joint;
      s1_ref_r   <= in_reference;
      s1_meas_r  <= in_measured;
    end
  end

  mjpi_state #(
    .NUM_JOINTS (NUM_JOINTS)
  ) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .joint    (s1_joint_r),
    .wr_en    (s1_valid_r && advance && in_range),
    .wr_err   (res.err),
    .wr_drive (res.next_drive),
    .rd_err   (prev_err),
    .rd_drive (prev_drive)
  );

  mjpi_core u_core (
    .reference  (s1_ref_r),
    .measured   (s1_meas_r),
    .prev_err   (prev_err),
    .prev_drive (prev_drive),
    .cfg        (cfg_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_joint_r   <= s1_joint_r;
      out_drive_r   <= in_range ? res.drive : '0;
      out_clamped_r <= in_range && res.clamped;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_joint_out = out_joint_r;
  assign out_drive     = out_drive_r;
  assign out_clamped   = out_clamped_r;

endmodule

/* test/pi_drive_checker.sv */
`timescale 1ns / 1ps
// checker that predicts and compares the drive results of the multi-joint pi controller
module pi_drive_checker #(
  parameter int NUM_JOINTS = mjpi_pkg::NUM_JOINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [mjpi_pkg::JOINT_W-1:0]      in_joint,
  input  logic [mjpi_pkg::LEVEL_W-1:0]      in_reference,
  input  logic [mjpi_pkg::LEVEL_W-1:0]      in_measured,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [mjpi_pkg::JOINT_W-1:0]      out_joint_out,
  input  logic [mjpi_pkg::LEVEL_W-1:0]      out_drive,
  input  logic                              out_clamped,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [mjpi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mjpi_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                fail_count,
  output int                                pending,
  output int                                checked_count,
  output int                                clamp_count,
  output int                                sat_count
);
  import mjpi_pkg::*;

  localparam longint DRIVE_HI = 64'sh7FFF_FFFF;
  localparam longint DRIVE_LO = -64'sh8000_0000;
  localparam longint GAIN_ONE = 64'sd1 << GAIN_FRAC;

  typedef struct packed {
    joint_t joint;
    level_t drive;
    logic   clamped;
  } drive_result_t;

  cfg_t          gains;
  err_t          prev_err [NUM_JOINTS];
  drive_t        prev_drive [NUM_JOINTS];
  drive_result_t drive_q [$];
  drive_result_t want;
  int            mismatches;
  int            results_seen;
  int            clamps;
  int            saturations;

  task automatic flag_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("%0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic advance_joint(input joint_t j, input level_t setpoint, input level_t sensed);
    longint        err_now;
    longint        err_old;
    longint        acc;
    longint        step;
    longint        sum;
    drive_result_t res;
    res.joint   = j;
    res.drive   = '0;
    res.clamped = 1'b0;
    // joints past the joint count leave all state alone
    if (j < NUM_JOINTS) begin
      err_now = longint'(setpoint) - longint'(sensed);
      err_old = longint'(prev_err[j]);
      acc = longint'(gains.prop_gain) * (err_now - err_old)
          + longint'(gains.integral_gain) * err_old;
      step = (acc < 0) ? -((-acc) / GAIN_ONE) : acc / GAIN_ONE;
      sum = longint'(prev_drive[j]) + step;
      if (sum > DRIVE_HI) begin
        sum = DRIVE_HI;
        saturations++;
      end else if (sum < DRIVE_LO) begin
        sum = DRIVE_LO;
        saturations++;
      end
      prev_err[j]   = err_t'(err_now);
      prev_drive[j] = drive_t'(sum);
      // low limit wins when the limits are crossed
      if (sum < longint'(gains.drive_min)) begin
        res.drive   = gains.drive_min;
        res.clamped = 1'b1;
      end else if (sum > longint'(gains.drive_max)) begin
        res.drive   = gains.drive_max;
        res.clamped = 1'b1;
      end else begin
        res.drive = level_t'(sum);
      end
    end
    drive_q.push_back(res);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gains.prop_gain     = PROP_GAIN_RST;
      gains.integral_gain = INTEGRAL_GAIN_RST;
      gains.drive_min     = DRIVE_MIN_RST;
      gains.drive_max     = DRIVE_MAX_RST;
      for (int k = 0; k < NUM_JOINTS; k++) begin
        prev_err[k]   = '0;
        prev_drive[k] = '0;
      end
      drive_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP_GAIN:     gains.prop_gain     = cfg_data;
          REG_INTEGRAL_GAIN: gains.integral_gain = cfg_data;
          REG_DRIVE_MIN:     gains.drive_min     = cfg_data[LEVEL_W-1:0];
          REG_DRIVE_MAX:     gains.drive_max     = cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        advance_joint(in_joint, in_reference, in_measured);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (drive_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d on joint %0d with no sample outstanding",
                                  results_seen, out_joint_out));
        end else begin
          want = drive_q.pop_front();
          if (want.clamped) begin
            clamps++;
          end
          if (out_joint_out !== want.joint) begin
            flag_mismatch($sformatf("result %0d: joint_out %0d, expected %0d",
                                    results_seen, out_joint_out, want.joint));
          end
          if (out_drive !== want.drive) begin
            flag_mismatch($sformatf("result %0d joint %0d: drive %0d, expected %0d",
                                    results_seen, want.joint, out_drive, want.drive));
          end
          if (out_clamped !== want.clamped) begin
            flag_mismatch($sformatf("result %0d joint %0d: clamped %b, expected %b",
                                    results_seen, want.joint, out_clamped, want.clamped));
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending       <= drive_q.size();
    checked_count <= results_seen;
    clamp_count   <= clamps;
    sat_count     <= saturations;
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// testbench top: clock, reset, stimulus and verdict for the multi-joint pi controller
module testbench;
  import mjpi_pkg::*;

  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     SAT_STEPS   = 40;
  localparam level_t LEVEL_TOP   = '1;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  joint_t                in_joint     = '0;
  level_t                in_reference = '0;
  level_t                in_measured  = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  joint_t                out_joint_out;
  level_t                out_drive;
  logic                  out_clamped;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  int fail_count;
  int pending;
  int checked_count;
  int clamp_count;
  int sat_count;
  int samples_sent;
  int reg_writes;
  int burst_left;
  int gap_max;
  int cycle_count;
  int stall_mode;
  int stall_left;
  int target [NUM_JOINTS_DEF];
  int plant [NUM_JOINTS_DEF];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  multi_joint_incremental_pi i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_joint      (in_joint),
    .in_reference  (in_reference),
    .in_measured   (in_measured),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_joint_out (out_joint_out),
    .out_drive     (out_drive),
    .out_clamped   (out_clamped),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  pi_drive_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_joint      (in_joint),
    .in_reference  (in_reference),
    .in_measured   (in_measured),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_joint_out (out_joint_out),
    .out_drive     (out_drive),
    .out_clamped   (out_clamped),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .clamp_count   (clamp_count),
    .sat_count     (sat_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("FAIL");
      $finish;
    end
  end

  // receiver stalls: none, short random, long random, or every other cycle
  always @(posedge clk) begin
    if (cycle_count % 64 == 0) begin
      stall_mode <= $urandom_range(0, 3);
    end
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (stall_mode == 1 && $urandom_range(0, 3) == 0) begin
        stall_left <= $urandom_range(1, 2);
      end else if (stall_mode == 2 && $urandom_range(0, 1) == 0) begin
        stall_left <= $urandom_range(1, 6);
      end else if (stall_mode == 3) begin
        stall_left <= 1;
      end
    end
  end

  task automatic send_sample(input joint_t j, input level_t setpoint, input level_t sensed);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid     <= 1'b1;
    in_joint     <= j;
    in_reference <= setpoint;
    in_measured  <= sensed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] kp, ki, lo, hi,
                               input logic [CFG_IDX_W-1:0] stray);
    drain();
    write_reg(REG_PROP_GAIN, kp);
    // unmapped index in the middle, must leave the gains alone
    write_reg(stray, CFG_DATA_W'($urandom));
    write_reg(REG_INTEGRAL_GAIN, ki);
    write_reg(REG_DRIVE_MIN, lo);
    write_reg(REG_DRIVE_MAX, hi);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_sample(input int track_weight);
    joint_t j;
    level_t setpoint;
    level_t sensed;
    int     noise;
    j = ($urandom_range(0, 9) == 0) ? joint_t'($urandom_range(6, 7))
                                    : joint_t'($urandom_range(0, 5));
    noise = $urandom_range(0, 8);
    if ($urandom_range(0, 9) < track_weight && j < NUM_JOINTS_DEF) begin
      // plant creeping toward its target with sensor noise
      if ($urandom_range(0, 19) == 0) begin
        target[j] = $urandom_range(0, 4095);
      end
      plant[j] = plant[j] + (target[j] - plant[j]) / 4 + noise - 4;
      if (plant[j] < 0) begin
        plant[j] = 0;
      end else if (plant[j] > 4095) begin
        plant[j] = 4095;
      end
      setpoint = level_t'(target[j]);
      sensed   = level_t'(plant[j]);
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          setpoint = ($urandom_range(0, 1) == 1) ? LEVEL_TOP : '0;
          sensed   = ($urandom_range(0, 1) == 1) ? LEVEL_TOP : '0;
        end
        1: begin
          setpoint = level_t'($urandom);
          sensed   = setpoint;
        end
        default: begin
          setpoint = level_t'($urandom);
          sensed   = level_t'($urandom);
        end
      endcase
    end
    send_sample(j, setpoint, sensed);
  endtask

  initial begin
    for (int k = 0; k < NUM_JOINTS_DEF; k++) begin
      target[k] = 2048;
      plant[k]  = 2048;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    gap_max = 4;

    // reset settings: full-scale steps both ways, truncation, limits, bad joints
    send_sample(0, LEVEL_TOP, '0);
    send_sample(0, '0, LEVEL_TOP);
    send_sample(0, 2048, 2048);
    send_sample(1, '0, LEVEL_TOP);
    send_sample(1, LEVEL_TOP, '0);
    send_sample(1, '0, '0);
    send_sample(2, 100, 90);
    send_sample(2, 90, 100);
    send_sample(2, 100, 100);
    send_sample(3, 41, 0);
    send_sample(3, 0, 0);
    send_sample(4, LEVEL_TOP, LEVEL_TOP);
    send_sample(4, '0, '0);
    send_sample(5, 40, 0);
    send_sample(5, 40, 0);
    send_sample(5, 0, 0);
    send_sample(6, LEVEL_TOP, LEVEL_TOP);
    send_sample(7, '0, LEVEL_TOP);
    send_sample(7, LEVEL_TOP, '0);
    send_sample(6, 1234, 567);

    // moderate gains, mostly tracking
    load_settings(16'd2048, 16'd64, 16'd100, 16'd4000, 8'd4);
    gap_max = 6;
    repeat (100) random_sample(7);

    // random settings, with a full drain halfway
    load_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), CFG_IDX_W'($urandom_range(5, 254)));
    gap_max = 8;
    repeat (50) random_sample(3);
    drain();
    repeat (50) random_sample(3);

    // pure integral at full gain: wind one joint up and one down
    load_settings(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 8'hFF);
    gap_max = 0;
    for (int n = 0; n < SAT_STEPS; n++) begin
      if (n == SAT_STEPS / 2) begin
        gap_max = 3;
      end
      send_sample(2, LEVEL_TOP, '0);
      send_sample(3, '0, LEVEL_TOP);
    end

    // crossed limits, full proportional gain, upper data bits set
    load_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'hF000, 8'd128);
    gap_max = 2;
    repeat (80) random_sample(4);

    // both limits on one level
    load_settings(CFG_DATA_W'($urandom_range(0, 1024)), CFG_DATA_W'($urandom_range(0, 64)),
                  16'd2048, 16'd2048, CFG_IDX_W'($urandom_range(4, 255)));
    gap_max = 5;
    repeat (60) random_sample(5);

    // back to the reset settings
    load_settings(CFG_DATA_W'(PROP_GAIN_RST), CFG_DATA_W'(INTEGRAL_GAIN_RST),
                  CFG_DATA_W'(DRIVE_MIN_RST), CFG_DATA_W'(DRIVE_MAX_RST),
                  CFG_IDX_W'($urandom_range(4, 255)));
    gap_max = 4;
    repeat (60) random_sample(5);

    drain();
    repeat (10) @(posedge clk);
    $display("%0d samples over seven gain and limit settings, %0d register writes",
             samples_sent, reg_writes);
    $display("%0d results checked, %0d clamped, %0d drive updates held at the 32-bit limits",
             checked_count, clamp_count, sat_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
